// File: rtl/asci_pkg.sv
// Shared constants, codes and types of the audio sample counter interface.
package asci_pkg;

  localparam logic [15:0] AddrControl = 16'h6C00;
  localparam logic [15:0] AddrVolume  = 16'h6C04;
  localparam logic [15:0] AddrCounter = 16'h6C08;
  localparam logic [15:0] AddrTiming  = 16'h6C0C;

  localparam logic [15:0] RateHigh = 16'd48000;
  localparam logic [15:0] RateLow  = 16'd32000;

  localparam logic [43:0] CpsReset = 44'hFFF_FFFF_FFFF;
  localparam logic [31:0] TpsReset = 32'd486000000;

  // control bit positions
  localparam int unsigned CbPlay  = 0;
  localparam int unsigned CbRate  = 1;
  localparam int unsigned CbMask  = 2;
  localparam int unsigned CbPend  = 3;
  localparam int unsigned CbValid = 4;
  localparam int unsigned CbScres = 5;
  localparam int unsigned CbDac   = 6;

  localparam logic [6:0] CbReset = 7'h02;

  // last step indices of the shared unit
  localparam logic [5:0] DivLastStep = 6'd63;
  localparam logic [5:0] MulLastStep = 6'd31;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2
  } asci_mode_e;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } asci_op_e;

  typedef struct packed {
    logic     start;
    asci_op_e op;
  } asci_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } asci_stat_t;

endpackage

// File: rtl/asci_intf.sv
// Valid/ready channel interfaces for request and response beats.
interface asci_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] address;
  logic [31:0] write_data;
  logic [63:0] now_ticks;

  modport source (output valid, mode, address, write_data, now_ticks, input ready);
  modport sink   (input valid, mode, address, write_data, now_ticks, output ready);
endinterface

interface asci_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        interrupt_line;
  logic        bad_address;

  modport source (output valid, read_data, interrupt_line, bad_address, input ready);
  modport sink   (input valid, read_data, interrupt_line, bad_address, output ready);
endinterface

// File: rtl/asci_iter_unit.sv
// Shared iterative unit: restoring 64/44-bit divider and 32x64 shift-add multiplier.
module asci_iter_unit
  import asci_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  asci_cmd_t   cmd_i,
  input  logic [63:0] opa_i,
  input  logic [43:0] opb_i,
  output asci_stat_t  stat_o,
  output logic [63:0] quo_o,
  output logic [63:0] prod_o
);

  asci_op_e    op_q, op_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] a_q, a_d;
  logic [63:0] b_q, b_d;
  logic [43:0] rem_q, rem_d;
  logic [63:0] acc_q, acc_d;
  logic [45:0] trial;
  logic        ge;
  logic        last;

  always_comb begin
    trial = {1'b0, rem_q, a_q[63]} - {2'b00, b_q[43:0]};
    ge    = ~trial[45];
    last  = (op_q == OP_DIV) ? (cnt_q == DivLastStep) : (cnt_q == MulLastStep);

    op_d   = op_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    rem_d  = rem_q;
    acc_d  = acc_q;

    if (cmd_i.start) begin
      op_d   = cmd_i.op;
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = opa_i;
      b_d    = {20'd0, opb_i};
      rem_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (op_q == OP_DIV) begin
        // shift in one dividend bit, subtract when it fits
        rem_d = ge ? trial[43:0] : {rem_q[42:0], a_q[63]};
        a_d   = {a_q[62:0], ge};
      end else begin
        acc_d = a_q[0] ? (acc_q + b_q) : acc_q;
        b_d   = {b_q[62:0], 1'b0};
        a_d   = {1'b0, a_q[63:1]};
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_DIV;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      op_q   <= op_d;
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = a_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/audio_sample_counter_interface.sv
// Top level of the audio interface register block with its sample counter.
//
//  channel  dir  handshake            beat contents
//  -------  ---  -------------------  ---------------------------------------------
//  req_i    in   valid/ready          mode, address, write_data, now_ticks
//  rsp_o    out  valid/ready          read_data, interrupt_line, bad_address
//  cfg      in   cfg_we_i (no ready)  cfg_wdata_i -> ticks per second
//
//  Reads, plain writes, mode three and ticks with play off or a zero period go
//  from accept straight to the response state; a tick with at most one sample
//  period elapsed passes the compare state first. A control write makes one
//  64-step pass of the shared divider. A tick that advances the counter runs
//  compare, 64 divide steps, 32 multiply steps and the interrupt update in turn.
//  One request is in flight at a time. The response sits in an output register,
//  so a stalled sink holds only the final step. Reset is asynchronous, active low.
module audio_sample_counter_interface
  import asci_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  asci_req_if.sink      req_i,
  asci_rsp_if.source    rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CPS,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_IRQ,
    ST_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] tps_q, tps_d;
  logic [6:0]  cb_q, cb_d;
  logic [31:0] vol_q, vol_d;
  logic [31:0] sc_q, sc_d;
  logic [31:0] tim_q, tim_d;
  logic [63:0] last_q, last_d;
  logic [43:0] cps_q, cps_d;
  logic [63:0] diff_q, diff_d;
  logic [31:0] n_q, n_d;
  logic [31:0] rd_q, rd_d;
  logic        bad_q, bad_d;

  logic        ovld_q, ovld_d;
  logic [31:0] ord_q, ord_d;
  logic        oirq_q, oirq_d;
  logic        obad_q, obad_d;

  asci_cmd_t   cmd;
  asci_stat_t  stat;
  logic [63:0] opa;
  logic [43:0] opb;
  logic [63:0] quo;
  logic [63:0] prod;

  logic        accept;
  logic [6:0]  wcb;
  logic [15:0] rate;

  asci_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .stat_o (stat),
    .quo_o  (quo),
    .prod_o (prod)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    tps_d   = cfg_we_i ? cfg_wdata_i : tps_q;
    cb_d    = cb_q;
    vol_d   = vol_q;
    sc_d    = sc_q;
    tim_d   = tim_q;
    last_d  = last_q;
    cps_d   = cps_q;
    diff_d  = diff_q;
    n_d     = n_q;
    rd_d    = rd_q;
    bad_d   = bad_q;
    ovld_d  = ovld_q && !rsp_o.ready;
    ord_d   = ord_q;
    oirq_d  = oirq_q;
    obad_d  = obad_q;
    cmd     = '{start: 1'b0, op: OP_DIV};
    opa     = diff_q;
    opb     = cps_q;

    // control write: take play/rate/mask/valid/DAC, write one to clear pending
    wcb  = '0;
    wcb[CbPlay]  = req_i.write_data[CbPlay];
    wcb[CbRate]  = req_i.write_data[CbRate];
    wcb[CbMask]  = req_i.write_data[CbMask];
    wcb[CbPend]  = cb_q[CbPend] && !req_i.write_data[CbPend];
    wcb[CbValid] = req_i.write_data[CbValid];
    wcb[CbDac]   = req_i.write_data[CbDac];
    rate = req_i.write_data[CbRate] ? RateHigh : RateLow;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d    = '0;
          bad_d   = 1'b0;
          state_d = ST_DONE;
          case (req_i.mode)
            MODE_READ: begin
              case (req_i.address)
                AddrControl: rd_d = {25'd0, cb_q};
                AddrVolume:  rd_d = vol_q;
                AddrCounter: begin
                  rd_d = sc_q;
                  if (cb_q[CbPlay]) sc_d = sc_q + 32'd1;
                end
                AddrTiming:  rd_d = tim_q;
                default:     bad_d = 1'b1;
              endcase
            end
            MODE_WRITE: begin
              case (req_i.address)
                AddrControl: begin
                  cb_d = wcb;
                  if ((req_i.write_data[CbPlay] != cb_q[CbPlay]) ||
                      req_i.write_data[CbScres]) begin
                    last_d = req_i.now_ticks;
                  end
                  if (req_i.write_data[CbScres]) sc_d = '0;
                  // ticks per sample = ticks per second / rate
                  cmd     = '{start: 1'b1, op: OP_DIV};
                  opa     = {32'd0, tps_q};
                  opb     = {28'd0, rate};
                  state_d = ST_CPS;
                end
                AddrVolume:  vol_d = req_i.write_data;
                AddrCounter: sc_d  = req_i.write_data;
                AddrTiming:  tim_d = req_i.write_data;
                default:     bad_d = 1'b1;
              endcase
            end
            MODE_TICK: begin
              if (cb_q[CbPlay] && (cps_q != '0)) begin
                diff_d  = req_i.now_ticks - last_q;
                state_d = ST_CMP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CPS: begin
        if (stat.done) begin
          cps_d   = quo[43:0];
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        // drop the tick unless more than one whole sample period has elapsed
        if (diff_q <= {20'd0, cps_q}) begin
          state_d = ST_DONE;
        end else begin
          cmd     = '{start: 1'b1, op: OP_DIV};
          opa     = diff_q;
          opb     = cps_q;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.done) begin
          n_d     = quo[31:0];
          cmd     = '{start: 1'b1, op: OP_MUL};
          opa     = {32'd0, quo[31:0]};
          opb     = cps_q;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stat.done) begin
          last_d  = last_q + prod;
          sc_d    = sc_q + n_q;
          state_d = ST_IRQ;
        end
      end
      ST_IRQ: begin
        if (cb_q[CbValid] && (sc_q >= tim_q)) cb_d[CbPend] = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!ovld_q || rsp_o.ready) begin
          ovld_d  = 1'b1;
          ord_d   = rd_q;
          oirq_d  = cb_q[CbPend] && cb_q[CbMask];
          obad_d  = bad_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tps_q   <= TpsReset;
      cb_q    <= CbReset;
      vol_q   <= '0;
      sc_q    <= '0;
      tim_q   <= '0;
      last_q  <= '0;
      cps_q   <= CpsReset;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tps_q   <= tps_d;
      cb_q    <= cb_d;
      vol_q   <= vol_d;
      sc_q    <= sc_d;
      tim_q   <= tim_d;
      last_q  <= last_d;
      cps_q   <= cps_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    n_q    <= n_d;
    rd_q   <= rd_d;
    bad_q  <= bad_d;
    ord_q  <= ord_d;
    oirq_q <= oirq_d;
    obad_q <= obad_d;
  end

  assign rsp_o.valid          = ovld_q;
  assign rsp_o.read_data      = ord_q;
  assign rsp_o.interrupt_line = oirq_q;
  assign rsp_o.bad_address    = obad_q;

endmodule
